### hw/rtl/ccwa_pkg.sv
// Package for the calendar clock with alarm.
// Holds the word layouts, register indexes, opcodes and counter limits.
// Used by every module in hw/rtl.
package ccwa_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [4:0]  DAY_MAX   = 5'd30;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;

  localparam logic [3:0]  CHIME_RESET = 4'd3;
  localparam logic [3:0]  ALARM_RESET = 4'd10;

  localparam logic [CFG_ADDR_W-1:0] CFG_CLOCK_RUN      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_SUPPRESS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_HOUR     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_MINUTE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHIME_REPEATS  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_REPEATS  = 3'd5;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_CLR_BUZZER = 2'd1,
    OP_LOAD_DATE  = 2'd2,
    OP_LOAD_TIME  = 2'd3
  } op_t;

  typedef struct packed {
    logic       clock_run;
    logic       alarm_suppress;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [3:0] chime_repeats;
    logic [3:0] alarm_repeats;
  } cfg_t;

  typedef struct packed {
    op_t         opcode;
    logic [13:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [3:0]  chime_left;
    logic [3:0]  alarm_left;
    logic        buzzer;
  } clk_state_t;

endpackage

### hw/rtl/ccwa_cfg_regs.sv
// Configuration registers of the calendar clock with alarm.
// Depends on ccwa_pkg for register indexes and the cfg_t layout.
module ccwa_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ccwa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ccwa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ccwa_pkg::cfg_t                 cfg
);

  ccwa_pkg::cfg_t cfg_r;
  ccwa_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        ccwa_pkg::CFG_CLOCK_RUN:      cfg_nxt.clock_run      = cfg_wdata[0];
        ccwa_pkg::CFG_ALARM_SUPPRESS: cfg_nxt.alarm_suppress = cfg_wdata[0];
        ccwa_pkg::CFG_ALARM_HOUR:     cfg_nxt.alarm_hour     = cfg_wdata[4:0];
        ccwa_pkg::CFG_ALARM_MINUTE:   cfg_nxt.alarm_minute   = cfg_wdata[5:0];
        ccwa_pkg::CFG_CHIME_REPEATS:  cfg_nxt.chime_repeats  = cfg_wdata[3:0];
        ccwa_pkg::CFG_ALARM_REPEATS:  cfg_nxt.alarm_repeats  = cfg_wdata[3:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_run      <= 1'b1;
      cfg_r.alarm_suppress <= 1'b0;
      cfg_r.alarm_hour     <= 5'd0;
      cfg_r.alarm_minute   <= 6'd0;
      cfg_r.chime_repeats  <= ccwa_pkg::CHIME_RESET;
      cfg_r.alarm_repeats  <= ccwa_pkg::ALARM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/ccwa_in_reg.sv
// Input register of the calendar clock with alarm: holds one accepted word.
// Depends on ccwa_pkg for the word layout.
module ccwa_in_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ccwa_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [ccwa_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                           take,
  output logic                           item_valid,
  output ccwa_pkg::in_item_t             item
);

  logic               vld_r;
  logic               vld_nxt;
  ccwa_pkg::in_item_t item_r;
  logic               accept;

  assign in_tready = !vld_r || take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.opcode     <= ccwa_pkg::op_t'(in_tuser[1:0]);
      item_r.new_year   <= in_tdata[13:0];
      item_r.new_month  <= in_tdata[17:14];
      item_r.new_day    <= in_tdata[22:18];
      item_r.new_hour   <= in_tdata[27:23];
      item_r.new_minute <= in_tdata[33:28];
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

### hw/rtl/ccwa_update.sv
// Next-state logic of the calendar clock with alarm: time cascade, loads,
// buzzer clear, hourly chime and alarm compare. Depends on ccwa_pkg.
module ccwa_update (
  input  ccwa_pkg::in_item_t   item,
  input  ccwa_pkg::cfg_t       cfg,
  input  ccwa_pkg::clk_state_t cur,
  output ccwa_pkg::clk_state_t nxt
);

  ccwa_pkg::clk_state_t adv;
  logic                 sec_wrap;
  logic                 min_wrap;
  logic                 hour_wrap;
  logic                 day_wrap;
  logic                 month_wrap;
  logic                 alarm_hit;
  logic                 buzz_mid;

  always_comb begin
    adv        = cur;
    sec_wrap   = (cur.second == ccwa_pkg::SEC_MAX);
    min_wrap   = sec_wrap && (cur.minute == ccwa_pkg::MIN_MAX);
    hour_wrap  = min_wrap && (cur.hour == ccwa_pkg::HOUR_MAX);
    day_wrap   = hour_wrap && (cur.day == ccwa_pkg::DAY_MAX);
    month_wrap = day_wrap && (cur.month == ccwa_pkg::MONTH_MAX);

    adv.second = sec_wrap ? 6'd0 : 6'(cur.second + 6'd1);
    if (sec_wrap) begin
      adv.minute = min_wrap ? 6'd0 : 6'(cur.minute + 6'd1);
    end
    if (min_wrap) begin
      adv.hour = hour_wrap ? 5'd0 : 5'(cur.hour + 5'd1);
    end
    if (hour_wrap) begin
      adv.day = day_wrap ? 5'd1 : 5'(cur.day + 5'd1);
    end
    if (day_wrap) begin
      adv.month = month_wrap ? 4'd1 : 4'(cur.month + 4'd1);
    end
    if (month_wrap && (cur.year < ccwa_pkg::YEAR_MAX)) begin
      adv.year = 14'(cur.year + 14'd1);
    end

    // hourly chime
    if (adv.minute == 6'd0) begin
      if ((cur.chime_left != 4'd0) && !cur.buzzer) begin
        adv.buzzer     = 1'b1;
        adv.chime_left = 4'(cur.chime_left - 4'd1);
      end
    end else begin
      adv.chime_left = cfg.chime_repeats;
    end
    buzz_mid = adv.buzzer;

    // alarm compare
    alarm_hit = (adv.hour == cfg.alarm_hour) && (adv.minute == cfg.alarm_minute);
    if (!cfg.alarm_suppress) begin
      if (alarm_hit) begin
        if ((cur.alarm_left != 4'd0) && !buzz_mid) begin
          adv.buzzer     = 1'b1;
          adv.alarm_left = 4'(cur.alarm_left - 4'd1);
        end
      end else begin
        adv.alarm_left = cfg.alarm_repeats;
      end
    end
  end

  always_comb begin
    nxt = cur;
    case (item.opcode)
      ccwa_pkg::OP_TICK: begin
        if (cfg.clock_run) begin
          nxt = adv;
        end
      end
      ccwa_pkg::OP_CLR_BUZZER: begin
        nxt.buzzer = 1'b0;
      end
      ccwa_pkg::OP_LOAD_DATE: begin
        nxt.year  = (item.new_year > ccwa_pkg::YEAR_MAX) ? ccwa_pkg::YEAR_MAX
                                                          : item.new_year;
        nxt.month = (item.new_month == 4'd0) ? 4'd1
                  : ((item.new_month > ccwa_pkg::MONTH_MAX) ? ccwa_pkg::MONTH_MAX
                                                            : item.new_month);
        nxt.day   = (item.new_day == 5'd0) ? 5'd1
                  : ((item.new_day > ccwa_pkg::DAY_MAX) ? ccwa_pkg::DAY_MAX
                                                        : item.new_day);
      end
      ccwa_pkg::OP_LOAD_TIME: begin
        nxt.hour   = (item.new_hour > ccwa_pkg::HOUR_MAX) ? ccwa_pkg::HOUR_MAX
                                                          : item.new_hour;
        nxt.minute = (item.new_minute > ccwa_pkg::MIN_MAX) ? ccwa_pkg::MIN_MAX
                                                           : item.new_minute;
        nxt.second = 6'd0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

### hw/rtl/calendar_clock_with_alarm.sv
// Top level of the calendar clock with alarm: input register, clock state,
// result register and configuration. Depends on ccwa_pkg, ccwa_cfg_regs,
// ccwa_in_reg and ccwa_update.
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  in_tdata (40), in_tuser (2)
//  out_     master     out_tvalid/out_tready out_tdata (48)
//  cfg_     write      cfg_we               cfg_addr (3), cfg_wdata (6)
//
// One word per cycle sustained while out_tready is high; a word waits in the
// input register and its result is registered in the result register.
// Clock state updates only when the result register can take the result.
// A stalled result register holds and the input register fills, then
// in_tready drops. Synchronous active-low reset restores the start time.
module calendar_clock_with_alarm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // new_year[13:0], new_month[17:14], new_day[22:18], new_hour[27:23],
  // new_minute[33:28], zero fill
  input  logic [ccwa_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [ccwa_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hour_now[4:0], minute_now[10:5], second_now[16:11], day_now[21:17],
  // month_now[25:22], year_now[39:26], buzzer_on[40], zero fill
  output logic [ccwa_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [ccwa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ccwa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ccwa_pkg::cfg_t                  cfg;
  ccwa_pkg::in_item_t              item;
  logic                            item_valid;
  logic                            adv;
  ccwa_pkg::clk_state_t            tm_r;
  ccwa_pkg::clk_state_t            tm_nxt;
  logic                            out_vld_r;
  logic                            out_vld_nxt;
  logic [ccwa_pkg::OUT_DATA_W-1:0] out_data_r;

  ccwa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccwa_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  ccwa_update u_upd (
    .item (item),
    .cfg  (cfg),
    .cur  (tm_r),
    .nxt  (tm_nxt)
  );

  assign adv = item_valid && (!out_vld_r || out_tready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r       <= 1'b0;
      tm_r.second     <= 6'd0;
      tm_r.minute     <= 6'd5;
      tm_r.hour       <= 5'd13;
      tm_r.day        <= 5'd14;
      tm_r.month      <= 4'd6;
      tm_r.year       <= 14'd2023;
      tm_r.chime_left <= ccwa_pkg::CHIME_RESET;
      tm_r.alarm_left <= ccwa_pkg::ALARM_RESET;
      tm_r.buzzer     <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        tm_r <= tm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {7'd0, tm_nxt.buzzer, tm_nxt.year, tm_nxt.month, tm_nxt.day,
                     tm_nxt.second, tm_nxt.minute, tm_nxt.hour};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tm_r.second <= ccwa_pkg::SEC_MAX) && (tm_r.minute <= ccwa_pkg::MIN_MAX) &&
    (tm_r.hour <= ccwa_pkg::HOUR_MAX))
    else $error("time counter out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tm_r.day != 5'd0) && (tm_r.day <= ccwa_pkg::DAY_MAX) &&
    (tm_r.month != 4'd0) && (tm_r.month <= ccwa_pkg::MONTH_MAX) &&
    (tm_r.year <= ccwa_pkg::YEAR_MAX))
    else $error("date counter out of range");

  a_buzzer_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tm_r.buzzer) |-> $past(adv && (item.opcode == ccwa_pkg::OP_TICK)))
    else $error("buzzer set without a tick");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tm_r))
    else $error("clock state changed without a word");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for calendar_clock_with_alarm: a cycle-free model of the
// clock, chime and alarm predicts every result word; random stalls on both streams.
// Depends on ccwa_pkg and the calendar_clock_with_alarm top level.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ccwa_pkg::CFG_ADDR_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [ccwa_pkg::CFG_ADDR_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        buzzer;
  } reading_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ccwa_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [ccwa_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ccwa_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic [ccwa_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [ccwa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  ccwa_pkg::cfg_t       cfg;
  ccwa_pkg::clk_state_t rtc;
  reading_t             due_readings[$];
  int                   words_sent = 0;
  int                   mismatches = 0;
  int                   stall_left = 0;
  int                   cycle_count = 0;
  bit                   calm = 1'b0;

  calendar_clock_with_alarm uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("calendar_clock_with_alarm test failed");
      $finish;
    end
  end

  task automatic reset_model();
    cfg.clock_run      = 1'b1;
    cfg.alarm_suppress = 1'b0;
    cfg.alarm_hour     = '0;
    cfg.alarm_minute   = '0;
    cfg.chime_repeats  = ccwa_pkg::CHIME_RESET;
    cfg.alarm_repeats  = ccwa_pkg::ALARM_RESET;
    rtc.second     = 6'd0;
    rtc.minute     = 6'd5;
    rtc.hour       = 5'd13;
    rtc.day        = 5'd14;
    rtc.month      = 4'd6;
    rtc.year       = 14'd2023;
    rtc.chime_left = ccwa_pkg::CHIME_RESET;
    rtc.alarm_left = ccwa_pkg::ALARM_RESET;
    rtc.buzzer     = 1'b0;
  endtask

  task automatic model_config(input logic [ccwa_pkg::CFG_ADDR_W-1:0] addr,
                              input logic [ccwa_pkg::CFG_DATA_W-1:0] data);
    case (addr)
      ccwa_pkg::CFG_CLOCK_RUN:      cfg.clock_run = data[0];
      ccwa_pkg::CFG_ALARM_SUPPRESS: cfg.alarm_suppress = data[0];
      ccwa_pkg::CFG_ALARM_HOUR:     cfg.alarm_hour = data[4:0];
      ccwa_pkg::CFG_ALARM_MINUTE:   cfg.alarm_minute = data[5:0];
      ccwa_pkg::CFG_CHIME_REPEATS:  cfg.chime_repeats = data[3:0];
      ccwa_pkg::CFG_ALARM_REPEATS:  cfg.alarm_repeats = data[3:0];
      default: ;
    endcase
  endtask

  task automatic rtc_tick();
    rtc.second = rtc.second + 6'd1;
    if (rtc.second > ccwa_pkg::SEC_MAX) begin
      rtc.second = 6'd0;
      rtc.minute = rtc.minute + 6'd1;
    end
    if (rtc.minute > ccwa_pkg::MIN_MAX) begin
      rtc.minute = 6'd0;
      rtc.hour = rtc.hour + 5'd1;
    end
    if (rtc.hour > ccwa_pkg::HOUR_MAX) begin
      rtc.hour = 5'd0;
      rtc.day = rtc.day + 5'd1;
    end
    if (rtc.day > ccwa_pkg::DAY_MAX) begin
      rtc.day = 5'd1;
      rtc.month = rtc.month + 4'd1;
    end
    if (rtc.month > ccwa_pkg::MONTH_MAX) begin
      rtc.month = 4'd1;
      if (rtc.year < ccwa_pkg::YEAR_MAX) rtc.year = rtc.year + 14'd1;
    end
    if (rtc.minute == 6'd0) begin
      if (rtc.chime_left != 4'd0 && !rtc.buzzer) begin
        rtc.buzzer = 1'b1;
        rtc.chime_left = rtc.chime_left - 4'd1;
      end
    end else begin
      rtc.chime_left = cfg.chime_repeats;
    end
    if (!cfg.alarm_suppress) begin
      if (rtc.hour == cfg.alarm_hour && rtc.minute == cfg.alarm_minute) begin
        if (rtc.alarm_left != 4'd0 && !rtc.buzzer) begin
          rtc.buzzer = 1'b1;
          rtc.alarm_left = rtc.alarm_left - 4'd1;
        end
      end else begin
        rtc.alarm_left = cfg.alarm_repeats;
      end
    end
  endtask

  task automatic rtc_apply(input ccwa_pkg::in_item_t w);
    reading_t r;
    case (w.opcode)
      ccwa_pkg::OP_TICK: if (cfg.clock_run) rtc_tick();
      ccwa_pkg::OP_CLR_BUZZER: rtc.buzzer = 1'b0;
      ccwa_pkg::OP_LOAD_DATE: begin
        rtc.year  = (w.new_year > ccwa_pkg::YEAR_MAX) ? ccwa_pkg::YEAR_MAX : w.new_year;
        rtc.month = (w.new_month < 4'd1) ? 4'd1 :
                    ((w.new_month > ccwa_pkg::MONTH_MAX) ? ccwa_pkg::MONTH_MAX : w.new_month);
        rtc.day   = (w.new_day < 5'd1) ? 5'd1 :
                    ((w.new_day > ccwa_pkg::DAY_MAX) ? ccwa_pkg::DAY_MAX : w.new_day);
      end
      default: begin
        rtc.hour   = (w.new_hour > ccwa_pkg::HOUR_MAX) ? ccwa_pkg::HOUR_MAX : w.new_hour;
        rtc.minute = (w.new_minute > ccwa_pkg::MIN_MAX) ? ccwa_pkg::MIN_MAX : w.new_minute;
        rtc.second = 6'd0;
      end
    endcase
    r.hour   = rtc.hour;
    r.minute = rtc.minute;
    r.second = rtc.second;
    r.day    = rtc.day;
    r.month  = rtc.month;
    r.year   = rtc.year;
    r.buzzer = rtc.buzzer;
    due_readings.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_readings.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        want = due_readings.pop_front();
        compare_field("hour_now", want.hour, out_tdata[4:0]);
        compare_field("minute_now", want.minute, out_tdata[10:5]);
        compare_field("second_now", want.second, out_tdata[16:11]);
        compare_field("day_now", want.day, out_tdata[21:17]);
        compare_field("month_now", want.month, out_tdata[25:22]);
        compare_field("year_now", want.year, out_tdata[39:26]);
        compare_field("buzzer_on", want.buzzer, out_tdata[40]);
      end
    end
    if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 10);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_word(input ccwa_pkg::in_item_t w);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.opcode;
    // new_year, new_month, new_day, new_hour, new_minute from bit 0 up
    in_tdata  <= {6'd0, w.new_minute, w.new_hour, w.new_day, w.new_month, w.new_year};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rtc_apply(w);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccwa_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [ccwa_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_config(addr, data);
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned run, input int unsigned suppress,
                            input int unsigned a_hour, input int unsigned a_minute,
                            input int unsigned chimes, input int unsigned alarms);
    write_reg(ccwa_pkg::CFG_CLOCK_RUN, 6'(run));
    write_reg(ccwa_pkg::CFG_ALARM_SUPPRESS, 6'(suppress));
    write_reg(ccwa_pkg::CFG_ALARM_HOUR, 6'(a_hour));
    write_reg(ccwa_pkg::CFG_ALARM_MINUTE, 6'(a_minute));
    write_reg(ccwa_pkg::CFG_CHIME_REPEATS, 6'(chimes));
    write_reg(ccwa_pkg::CFG_ALARM_REPEATS, 6'(alarms));
  endtask

  function automatic ccwa_pkg::in_item_t random_word(input ccwa_pkg::op_t op);
    ccwa_pkg::in_item_t w;
    w.opcode     = op;
    w.new_year   = 14'($urandom_range(0, 16383));
    w.new_month  = 4'($urandom_range(0, 15));
    w.new_day    = 5'($urandom_range(0, 31));
    w.new_hour   = 5'($urandom_range(0, 31));
    w.new_minute = 6'($urandom_range(0, 63));
    return w;
  endfunction

  function automatic ccwa_pkg::in_item_t make_word(input ccwa_pkg::op_t op,
                                                   input int unsigned y, input int unsigned mo,
                                                   input int unsigned d, input int unsigned h,
                                                   input int unsigned mi);
    ccwa_pkg::in_item_t w;
    w.opcode     = op;
    w.new_year   = 14'(y);
    w.new_month  = 4'(mo);
    w.new_day    = 5'(d);
    w.new_hour   = 5'(h);
    w.new_minute = 6'(mi);
    return w;
  endfunction

  function automatic ccwa_pkg::in_item_t time_word(input int unsigned h, input int unsigned mi);
    ccwa_pkg::in_item_t w;
    w = random_word(ccwa_pkg::OP_LOAD_TIME);
    w.new_hour   = 5'(h);
    w.new_minute = 6'(mi);
    return w;
  endfunction

  task automatic tick_burst(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_word(random_word(ccwa_pkg::OP_CLR_BUZZER));
      send_word(random_word(ccwa_pkg::OP_TICK));
    end
  endtask

  task automatic run_traffic(input int n_words);
    int start;
    ccwa_pkg::in_item_t w;
    start = words_sent;
    while (words_sent - start < n_words) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 4))
          send_word(random_word(ccwa_pkg::op_t'($urandom_range(0, 3))));
        2: begin
          w = random_word(ccwa_pkg::OP_LOAD_DATE);
          w.new_year  = $urandom_range(0, 1) ? 14'd9999 : 14'($urandom_range(0, 9998));
          w.new_month = 4'd12;
          w.new_day   = 5'd30;
          send_word(w);
          send_word(time_word(23, 59));
          tick_burst($urandom_range(60, 70));
        end
        3: begin
          w = random_word(ccwa_pkg::OP_LOAD_DATE);
          w.new_year  = 14'($urandom_range(0, 9999));
          w.new_month = 4'($urandom_range(1, 12));
          w.new_day   = 5'd30;
          send_word(w);
          send_word(time_word(23, 59));
          tick_burst($urandom_range(60, 70));
        end
        4, 5: begin
          send_word(time_word($urandom_range(0, 23), 59));
          tick_burst($urandom_range(58, 75));
        end
        6, 7: begin
          send_word(time_word(cfg.alarm_hour, cfg.alarm_minute));
          tick_burst($urandom_range(10, 70));
        end
        8: tick_burst($urandom_range(5, 30));
        default: begin
          send_word(random_word(ccwa_pkg::OP_LOAD_DATE));
          send_word(random_word(ccwa_pkg::OP_LOAD_TIME));
          tick_burst($urandom_range(1, 10));
        end
      endcase
    end
  endtask

  task automatic test_reset_values();
    send_word(make_word(ccwa_pkg::OP_CLR_BUZZER, 0, 0, 0, 0, 0));
  endtask

  task automatic test_field_limits();
    send_word(make_word(ccwa_pkg::OP_LOAD_DATE, 0, 0, 0, 0, 0));
    send_word(make_word(ccwa_pkg::OP_LOAD_DATE, 16383, 15, 31, 31, 63));
    send_word(make_word(ccwa_pkg::OP_LOAD_DATE, 10000, 13, 1, 0, 0));
    send_word(make_word(ccwa_pkg::OP_LOAD_DATE, 9999, 12, 30, 0, 0));
    send_word(make_word(ccwa_pkg::OP_LOAD_TIME, 16383, 15, 31, 31, 63));
    send_word(make_word(ccwa_pkg::OP_LOAD_TIME, 0, 0, 0, 24, 60));
    send_word(make_word(ccwa_pkg::OP_TICK, 0, 0, 0, 0, 0));
    send_word(make_word(ccwa_pkg::OP_LOAD_TIME, 0, 0, 0, 0, 0));
    // chime budget runs out over three ticks, then the alarm at midnight takes over
    repeat (4) begin
      send_word(make_word(ccwa_pkg::OP_TICK, 16383, 15, 31, 31, 63));
      send_word(make_word(ccwa_pkg::OP_CLR_BUZZER, 16383, 15, 31, 31, 63));
    end
    send_word(make_word(ccwa_pkg::OP_TICK, 0, 0, 0, 0, 0));
    send_word(make_word(ccwa_pkg::OP_LOAD_DATE, 2024, 7, 15, 0, 0));
    send_word(make_word(ccwa_pkg::OP_LOAD_TIME, 0, 0, 0, 12, 30));
    send_word(make_word(ccwa_pkg::OP_TICK, 0, 0, 0, 0, 0));
    send_word(make_word(ccwa_pkg::OP_CLR_BUZZER, 0, 0, 0, 0, 0));
  endtask

  task automatic test_spare_registers();
    write_reg(CFG_SPARE_6, 6'h3F);
    write_reg(CFG_SPARE_7, 6'h3F);
    write_reg(CFG_SPARE_6, 6'h00);
    repeat (4) send_word(random_word(ccwa_pkg::OP_TICK));
  endtask

  task automatic test_running_clock();
    set_config(1, 0, $urandom_range(0, 23), $urandom_range(0, 59),
               ccwa_pkg::CHIME_RESET, ccwa_pkg::ALARM_RESET);
    run_traffic(250);
  endtask

  task automatic test_stopped_clock();
    set_config(6'h3E, 0, $urandom_range(0, 23), $urandom_range(0, 59),
               $urandom_range(0, 15), $urandom_range(0, 15));
    run_traffic(100);
  endtask

  task automatic test_alarm_suppressed();
    set_config(1, 6'h3F, $urandom_range(0, 23), $urandom_range(0, 59),
               $urandom_range(1, 15), $urandom_range(1, 15));
    run_traffic(200);
  endtask

  task automatic test_zero_budgets();
    set_config(1, 0, 0, 0, 0, 0);
    run_traffic(200);
  endtask

  task automatic test_full_budgets();
    set_config(1, 0, 23, 59, 6'h3F, 6'h3F);
    run_traffic(200);
  endtask

  task automatic test_alarm_out_of_range();
    set_config(1, 0, 6'h3F, 6'h3F, 1, 1);
    run_traffic(150);
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    set_config(1, 0, $urandom_range(0, 23), 0, 2, 5);
    run_traffic(250);
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_values();
    test_field_limits();
    test_spare_registers();
    test_running_clock();
    test_stopped_clock();
    test_alarm_suppressed();
    test_zero_budgets();
    test_full_budgets();
    test_alarm_out_of_range();
    test_steady_stream();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_readings.size() == 0) begin
      $display("calendar_clock_with_alarm test passed");
    end else begin
      $display("calendar_clock_with_alarm test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ccwa_pkg.sv
hw/rtl/ccwa_cfg_regs.sv
hw/rtl/ccwa_in_reg.sv
hw/rtl/ccwa_update.sv
hw/rtl/calendar_clock_with_alarm.sv
tb/testbench.sv
